// File: rtl/gc_victim_cost_select_top_macros.svh
`ifndef GC_VICTIM_COST_SELECT_TOP_MACROS_SVH
`define GC_VICTIM_COST_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCVCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gcvcs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCVCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gcvcs assertion failed");

`endif

// File: rtl/gcvcs_pkg.sv
`timescale 1ns / 1ps

package gcvcs_pkg;

    localparam int PAGES_PER_BLOCK = 4096;

    localparam int VALID_W  = 13;
    localparam int ERASE_W  = 16;
    localparam int NUMBER_W = 16;
    localparam int WEIGHT_W = 20;
    localparam int COST_W   = 48;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 20;

    localparam int PROD_W     = VALID_W + ERASE_W;
    localparam int DIVIDEND_W = PROD_W + FRAC_W;
    localparam int DIV_STEPS  = (DIVIDEND_W + 1) / 2;
    localparam int DQ_W       = 2 * DIV_STEPS;
    localparam int WEAR_W     = WEIGHT_W + ERASE_W;
    localparam int SUM_W      = DQ_W + 1;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [ERASE_W-1:0]  ERASE_LIMIT_RESET = 16'd3000;
    localparam logic [WEIGHT_W-1:0] WEAR_WEIGHT_RESET = 20'd3277;

    typedef enum logic {
        CFG_ERASE_LIMIT = 1'b0,
        CFG_WEAR_WEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SUM,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic sum;
        logic update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic qual;
        logic last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/gcvcs_ctrl.sv
`timescale 1ns / 1ps
`include "gc_victim_cost_select_top_macros.svh"

module gcvcs_ctrl
    import gcvcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = '0;
                n_state   = i_sts.qual ? S_DIV : S_UPDATE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `GCVCS_ASSERT_NOW(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `GCVCS_ASSERT_NEXT(a_qual_enters_div, i_clk, i_rst_n, (r_state == S_MUL) && i_sts.qual, (r_state == S_DIV) && (r_step == '0))
    `GCVCS_ASSERT_NEXT(a_div_to_sum, i_clk, i_rst_n, (r_state == S_DIV) && (r_step == LAST_STEP), r_state == S_SUM)
    `GCVCS_ASSERT_NEXT(a_plain_item_ends, i_clk, i_rst_n, (r_state == S_UPDATE) && !i_sts.last, o_ready)

endmodule

// File: rtl/gcvcs_dp.sv
`timescale 1ns / 1ps
`include "gc_victim_cost_select_top_macros.svh"

module gcvcs_dp
    import gcvcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_sts,
    input  logic                i_cfg_we,
    input  t_cfg_reg            i_cfg_reg,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [VALID_W-1:0]  i_valid_pages,
    input  logic [ERASE_W-1:0]  i_pe_count,
    input  logic [NUMBER_W-1:0] i_candidate_number,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NUMBER_W-1:0] o_victim_number,
    output logic                o_found,
    output logic [COST_W-1:0]   o_victim_cost
);

    localparam logic [17:0] PAGES_MAX = 18'(PAGES_PER_BLOCK);

    logic [ERASE_W-1:0]  r_erase_limit;
    logic [WEIGHT_W-1:0] r_wear_weight;

    logic [VALID_W-1:0]  r_valid;
    logic [ERASE_W-1:0]  r_erase;
    logic [ERASE_W-1:0]  r_div;
    logic [NUMBER_W-1:0] r_number;
    logic                r_last;
    logic                r_qual;

    logic [DQ_W-1:0]     r_dq;
    logic [ERASE_W-1:0]  r_rem;
    logic [WEAR_W-1:0]   r_wear;
    logic [COST_W-1:0]   r_cost;

    logic [COST_W-1:0]   r_best_cost;
    logic [NUMBER_W-1:0] r_best_number;
    logic                r_have_best;

    logic                r_out_valid;
    logic [NUMBER_W-1:0] r_out_number;
    logic                r_out_found;
    logic [COST_W-1:0]   r_out_cost;

    logic [VALID_W-1:0]  valid_sat;
    logic [PROD_W-1:0]   prod;
    logic [ERASE_W:0]    t1;
    logic [ERASE_W:0]    t2;
    logic                ge1;
    logic                ge2;
    logic [ERASE_W-1:0]  rem1;
    logic [ERASE_W-1:0]  rem2;
    logic [SUM_W-1:0]    sum;
    logic                take;

    always_comb begin
        valid_sat = (18'(i_valid_pages) > PAGES_MAX) ? PAGES_MAX[VALID_W-1:0] : i_valid_pages;
        prod      = PROD_W'(r_valid) * PROD_W'(r_erase_limit);

        t1   = {r_rem, r_dq[DQ_W-1]};
        ge1  = t1 >= {1'b0, r_div};
        rem1 = ge1 ? ERASE_W'(t1 - {1'b0, r_div}) : t1[ERASE_W-1:0];
        t2   = {rem1, r_dq[DQ_W-2]};
        ge2  = t2 >= {1'b0, r_div};
        rem2 = ge2 ? ERASE_W'(t2 - {1'b0, r_div}) : t2[ERASE_W-1:0];

        // The quotient and wear term together stay below 2^48, so the sum never saturates.
        sum  = SUM_W'(r_dq) + SUM_W'(r_wear);
        take = r_qual && (!r_have_best || (r_cost < r_best_cost));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_limit <= ERASE_LIMIT_RESET;
            r_wear_weight <= WEAR_WEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_reg)
                CFG_ERASE_LIMIT: r_erase_limit <= i_cfg_data[ERASE_W-1:0];
                CFG_WEAR_WEIGHT: r_wear_weight <= i_cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_valid  <= valid_sat;
            r_erase  <= i_pe_count;
            r_div    <= r_erase_limit - i_pe_count;
            r_number <= i_candidate_number;
            r_last   <= i_last;
            r_qual   <= i_pe_count < r_erase_limit;
        end
        if (i_cmd.mul) begin
            r_dq   <= DQ_W'({prod, FRAC_W'(0)});
            r_rem  <= '0;
            r_wear <= WEAR_W'(r_wear_weight) * WEAR_W'(r_erase);
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DQ_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
        if (i_cmd.sum) begin
            r_cost <= COST_W'(sum);
        end
        if (i_cmd.out_load) begin
            r_out_number <= r_best_number;
            r_out_found  <= r_have_best;
            r_out_cost   <= r_best_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_cost   <= '1;
            r_best_number <= '0;
            r_have_best   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_best_cost   <= '1;
                r_best_number <= '0;
                r_have_best   <= 1'b0;
            end else if (i_cmd.update && take) begin
                r_best_cost   <= r_cost;
                r_best_number <= r_number;
                r_have_best   <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.qual     = r_qual;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_victim_number = r_out_number;
    assign o_found         = r_out_found;
    assign o_victim_cost   = r_out_cost;

    `GCVCS_ASSERT_NEXT(a_round_cleared, i_clk, i_rst_n, i_cmd.out_load, !r_have_best && (r_best_cost == '1) && (r_best_number == '0))
    `GCVCS_ASSERT_NEXT(a_empty_round_cost, i_clk, i_rst_n, i_cmd.out_load && !r_have_best, o_valid && !o_found && (o_victim_cost == '1))

endmodule

// File: rtl/gc_victim_cost_select_top.sv
// Cost-benefit victim selection for flash garbage collection.
// The input channel carries one candidate block per transaction: valid page
// count, program/erase count, block number and a last mark. Each block costs
// valid_pages * erase_limit / (erase_limit - pe_count) plus
// wear_weight * pe_count, in Q32.16; blocks at or above the erase limit
// are skipped. The lowest cost wins, and the earlier block wins a tie.
// The transaction marked last produces one output transaction with the
// victim number, a found flag and its cost, and then clears the round.
// A costed candidate passes the multiply, divide, sum and update states
// before the next one is accepted; a skipped block goes from multiply to
// update, and the last one then loads the result in the output state.
// The divide state uses the shared restoring divider, which retires two
// quotient bits per cycle for a 45-bit dividend.
// The result sits in an output register, so the next candidate is accepted
// while it waits; a stalled receiver only holds up the next last candidate.
// The configuration channel is always ready and must only be used while idle.
// Reset restores erase_limit to 3000 and wear_weight to 3277 and empties
// the round.
`timescale 1ns / 1ps

module gc_victim_cost_select_top
    import gcvcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VALID_W-1:0]  i_valid_pages,
    input  logic [ERASE_W-1:0]  i_pe_count,
    input  logic [NUMBER_W-1:0] i_candidate_number,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NUMBER_W-1:0] o_victim_number,
    output logic                o_found,
    output logic [COST_W-1:0]   o_victim_cost,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_reg            i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    assign o_cfg_ready = 1'b1;

    gcvcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gcvcs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_reg          (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid_pages      (i_valid_pages),
        .i_pe_count         (i_pe_count),
        .i_candidate_number (i_candidate_number),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_victim_number    (o_victim_number),
        .o_found            (o_found),
        .o_victim_cost      (o_victim_cost)
    );

endmodule

// File: tb/sv/gc_victim_cost_select_top_test.sv
`timescale 1ns / 1ps

module gc_victim_cost_select_top_test;
    import gcvcs_pkg::*;

    localparam logic [COST_W-1:0] NO_COST = {COST_W{1'b1}};
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [VALID_W-1:0]  pages;
        logic [ERASE_W-1:0]  erases;
        logic [NUMBER_W-1:0] number;
        logic                last;
    } t_candidate;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                found;
        logic [COST_W-1:0]   cost;
    } t_victim;

    typedef struct packed {
        logic [VALID_W-1:0]  pages;
        logic [ERASE_W-1:0]  erases;
        logic [NUMBER_W-1:0] number;
        logic                last;
        logic                typed;
        logic [NUMBER_W-1:0] exp_number;
        logic                exp_found;
        logic [COST_W-1:0]   exp_cost;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [19] = '{
        '{13'd0,    16'd0,     16'h1234, 1'b1, 1'b1, 16'h1234, 1'b1, 48'd0},
        '{13'd4096, 16'd3000,  16'd5,    1'b1, 1'b1, 16'd0,    1'b0, NO_COST},
        '{13'd8191, 16'd0,     16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 48'h0000_1000_0000},
        '{13'd100,  16'd0,     16'd7,    1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd100,  16'd0,     16'd8,    1'b1, 1'b1, 16'd7,    1'b1, 48'h0000_0064_0000},
        '{13'd200,  16'd0,     16'd1,    1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd100,  16'd0,     16'd2,    1'b1, 1'b1, 16'd2,    1'b1, 48'h0000_0064_0000},
        '{13'd4096, 16'd2999,  16'd9,    1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd1,    16'hFFFF,  16'd10,   1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd4096, 16'd2999,  16'hAAAA, 1'b1, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd50,   16'd100,   16'd11,   1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd40,   16'd2000,  16'd12,   1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd60,   16'd0,     16'd13,   1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd5000, 16'd1,     16'h5555, 1'b1, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd0,    16'd3000,  16'd3,    1'b0, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd10,   16'd10,    16'd4,    1'b1, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd1,    16'hFFFF,  16'd20,   1'b1, 1'b1, 16'd0,    1'b0, NO_COST},
        '{13'd0,    16'd2999,  16'd0,    1'b1, 1'b0, 16'd0,    1'b0, 48'd0},
        '{13'd4095, 16'd1,     16'd0,    1'b1, 1'b0, 16'd0,    1'b0, 48'd0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [VALID_W-1:0]  i_valid_pages;
    logic [ERASE_W-1:0]  i_pe_count;
    logic [NUMBER_W-1:0] i_candidate_number;
    logic                i_last;
    logic                o_valid;
    logic                i_ready;
    logic [NUMBER_W-1:0] o_victim_number;
    logic                o_found;
    logic [COST_W-1:0]   o_victim_cost;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_reg            i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    logic [ERASE_W-1:0]  erase_limit_q = ERASE_LIMIT_RESET;
    logic [WEIGHT_W-1:0] wear_weight_q = WEAR_WEIGHT_RESET;
    logic [COST_W-1:0]   round_best_cost = NO_COST;
    logic [NUMBER_W-1:0] round_best_number = '0;
    logic                round_has_best = 1'b0;

    t_victim pending_victims [$];
    int error_count = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 70;
    int rx_hold_left = 0;
    logic [VALID_W-1:0] prev_pages = '0;
    logic [ERASE_W-1:0] prev_erases = '0;

    gc_victim_cost_select_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_valid_pages      (i_valid_pages),
        .i_pe_count         (i_pe_count),
        .i_candidate_number (i_candidate_number),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_victim_number    (o_victim_number),
        .o_found            (o_found),
        .o_victim_cost      (o_victim_cost),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit block_cost(input logic [VALID_W-1:0] pages,
                                      input logic [ERASE_W-1:0] erases,
                                      output logic [COST_W-1:0] cost);
        logic [63:0] limit;
        logic [63:0] used;
        logic [63:0] held;
        logic [63:0] ratio;
        logic [63:0] total;
        limit = 64'(erase_limit_q);
        used  = 64'(erases);
        cost  = NO_COST;
        if (used >= limit) begin
            return 1'b0;
        end
        held  = (pages > PAGES_PER_BLOCK) ? 64'(PAGES_PER_BLOCK) : 64'(pages);
        ratio = ((held << FRAC_W) * limit) / (limit - used);
        total = ratio + 64'(wear_weight_q) * used;
        cost  = (total > 64'(NO_COST)) ? NO_COST : total[COST_W-1:0];
        return 1'b1;
    endfunction

    task automatic fold_candidate(input t_candidate c, output bit produced,
                                  output t_victim v);
        logic [COST_W-1:0] cost;
        if (block_cost(c.pages, c.erases, cost)) begin
            if (!round_has_best || cost < round_best_cost) begin
                round_best_cost   = cost;
                round_best_number = c.number;
                round_has_best    = 1'b1;
            end
        end
        produced = c.last;
        v.number = round_has_best ? round_best_number : '0;
        v.found  = round_has_best;
        v.cost   = round_has_best ? round_best_cost : NO_COST;
        if (c.last) begin
            round_best_cost   = NO_COST;
            round_best_number = '0;
            round_has_best    = 1'b0;
        end
    endtask

    task automatic offer_candidate(input t_candidate c, input bit typed,
                                   input t_victim typed_v);
        bit produced;
        t_victim v;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid            = 1'b1;
        i_valid_pages      = c.pages;
        i_pe_count         = c.erases;
        i_candidate_number = c.number;
        i_last             = c.last;
        do @(posedge i_clk); while (!o_ready);
        fold_candidate(c, produced, v);
        if (produced) begin
            pending_victims.push_back(typed ? typed_v : v);
        end
    endtask

    task automatic wait_idle(input int extra);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_victims.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ERASE_LIMIT) begin
            erase_limit_q = data[ERASE_W-1:0];
        end else begin
            wear_weight_q = data[WEIGHT_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_candidate random_candidate(input bit is_last);
        t_candidate c;
        int limit;
        int sel;
        limit = int'(erase_limit_q);
        case ($urandom_range(3))
            0: c.pages = VALID_W'($urandom_range(PAGES_PER_BLOCK));
            1: c.pages = VALID_W'($urandom);
            2: c.pages = VALID_W'($urandom_range(1) ? PAGES_PER_BLOCK : 0);
            default: c.pages = VALID_W'($urandom_range(PAGES_PER_BLOCK, 3500));
        endcase
        sel = $urandom_range(9);
        if (sel <= 5) begin
            c.erases = ERASE_W'((limit == 0) ? 0 : $urandom_range(limit - 1));
        end else if (sel <= 7) begin
            c.erases = ERASE_W'((limit == 0) ? 0
                       : limit - 1 - $urandom_range((limit > 8) ? 8 : limit - 1));
        end else if (sel == 8) begin
            c.erases = ERASE_W'($urandom_range(65535, limit));
        end else begin
            c.erases = ERASE_W'($urandom);
        end
        if ($urandom_range(7) == 0) begin
            c.pages  = prev_pages;
            c.erases = prev_erases;
        end
        c.number    = NUMBER_W'($urandom);
        c.last      = is_last;
        prev_pages  = c.pages;
        prev_erases = c.erases;
        return c;
    endfunction

    task automatic run_random_rounds(input int count, input int pause_at);
        int sent;
        int round_len;
        bit paused;
        t_candidate c;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            round_len = ($urandom_range(9) == 0) ? $urandom_range(24, 8)
                                                 : $urandom_range(6, 1);
            for (int k = 0; k < round_len; k++) begin
                c = random_candidate(k == round_len - 1);
                offer_candidate(c, 1'b0, '0);
                sent++;
            end
            if (!paused && pause_at > 0 && sent >= pause_at) begin
                paused = 1'b1;
                wait_idle(0);
            end
        end
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_ready = 1'b0;
                rx_hold_left--;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_victim want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_victims.size() == 0) begin
                $error("unexpected victim transaction: number %h found %b cost %h",
                       o_victim_number, o_found, o_victim_cost);
                error_count++;
            end else begin
                want = pending_victims.pop_front();
                if (o_victim_number !== want.number) begin
                    $error("victim_number: expected %h, got %h", want.number,
                           o_victim_number);
                    error_count++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, o_found);
                    error_count++;
                end
                if (o_victim_cost !== want.cost) begin
                    $error("victim_cost: expected %h, got %h", want.cost, o_victim_cost);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("gc_victim_cost_select_top_test NOT OK");
        $finish;
    end

    initial begin
        t_candidate c;
        t_victim v;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_valid_pages      = '0;
        i_pe_count         = '0;
        i_candidate_number = '0;
        i_last             = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_ERASE_LIMIT;
        i_cfg_data         = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            c.pages  = DIRECTED_ROWS[r].pages;
            c.erases = DIRECTED_ROWS[r].erases;
            c.number = DIRECTED_ROWS[r].number;
            c.last   = DIRECTED_ROWS[r].last;
            v.number = DIRECTED_ROWS[r].exp_number;
            v.found  = DIRECTED_ROWS[r].exp_found;
            v.cost   = DIRECTED_ROWS[r].exp_cost;
            offer_candidate(c, DIRECTED_ROWS[r].typed, v);
        end

        for (int s = 0; s < 6; s++) begin
            if (s > 0) begin
                wait_idle(SETTLE_CYCLES);
                case (s)
                    1: begin
                        write_register(CFG_ERASE_LIMIT, {4'hF, 16'hFFFF});
                        write_register(CFG_WEAR_WEIGHT, 20'hFFFFF);
                    end
                    2: begin
                        write_register(CFG_ERASE_LIMIT, 20'd1);
                        write_register(CFG_WEAR_WEIGHT, 20'd0);
                    end
                    3: begin
                        write_register(CFG_ERASE_LIMIT, {4'($urandom), 16'd0});
                        write_register(CFG_WEAR_WEIGHT, CFG_W'($urandom));
                    end
                    4: begin
                        write_register(CFG_ERASE_LIMIT, CFG_W'($urandom_range(65535, 1)));
                        write_register(CFG_WEAR_WEIGHT, CFG_W'($urandom));
                    end
                    default: begin
                        write_register(CFG_ERASE_LIMIT, CFG_W'($urandom_range(64, 2)));
                        write_register(CFG_WEAR_WEIGHT, CFG_W'($urandom));
                    end
                endcase
            end
            case (s / 2)
                0: begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 70;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 13;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (s == 1) begin
                rx_hold_left = 1500;
            end
            run_random_rounds(330, (s == 4) ? 150 : 0);
        end

        wait_idle(SETTLE_CYCLES);
        if (error_count == 0) begin
            $display("gc_victim_cost_select_top_test OK");
        end else begin
            $display("gc_victim_cost_select_top_test NOT OK");
        end
        $finish;
    end

endmodule
